>>> sv/lpht_pkg.sv
// Shared types and constants for the linear-probe hash table core.
// No dependencies; imported by every module of the block.
package lpht_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int KEY_W           = 31;
  localparam int PAY_W           = 32;
  localparam int SLOT_W          = 7;
  localparam int SIZE_W          = 8;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd128;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_STORED    = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } lpht_status_t;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } lpht_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    lpht_status_t      status;
    logic [PAY_W-1:0]  found_payload;
  } lpht_out_t;

  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } lpht_entry_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } lpht_fr_state_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_CHECK
  } lpht_bk_state_t;

endpackage

>>> sv/lpht_front.sv
// Front end: accepts commands and works out the home slot (key mod size),
// one quotient bit per cycle, then pushes the item to the queue. Uses lpht_pkg.
module lpht_front import lpht_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int IW = $clog2(TABLE_DEPTH),
  localparam int SW = IW + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  lpht_in_t      in_item,
  input  logic [SW-1:0] eff_size,
  input  logic          clearing,
  input  logic          q_full,
  output logic          q_push,
  output lpht_in_t      q_item,
  output logic [IW-1:0] q_home
);

  localparam int CNT_W = $clog2(KEY_W);

  lpht_fr_state_t   state_r, state_nxt;
  lpht_in_t         item_r, item_nxt;
  logic [KEY_W-1:0] sh_r, sh_nxt;
  logic [SW-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SW:0]      trial;
  logic             accept;

  assign busy   = (state_r != FR_IDLE) || clearing;
  assign accept = start && !busy;
  assign trial  = {rem_r, sh_r[KEY_W-1]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE: if (accept) state_nxt = FR_DIV;
      FR_DIV:  if (cnt_r == CNT_W'(KEY_W - 1)) state_nxt = FR_PUSH;
      FR_PUSH: if (!q_full) state_nxt = FR_IDLE;
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_comb begin
    item_nxt = item_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    q_push   = 1'b0;
    case (state_r)
      FR_IDLE: begin
        if (accept) begin
          item_nxt = in_item;
          sh_nxt   = in_item.key;
          rem_nxt  = '0;
          cnt_nxt  = '0;
        end
      end
      FR_DIV: begin
        if (trial >= {1'b0, eff_size}) begin
          rem_nxt = SW'(trial - {1'b0, eff_size});
        end else begin
          rem_nxt = trial[SW-1:0];
        end
        sh_nxt  = {sh_r[KEY_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
      end
      FR_PUSH: q_push = !q_full;
      default: q_push = 1'b0;
    endcase
  end

  assign q_item = item_r;
  assign q_home = rem_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

>>> sv/lpht_queue.sv
// Two-entry queue between front and back ends.
// Generic width; uses lpht_pkg only for house consistency of imports.
module lpht_queue import lpht_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] buf_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = buf_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? !wp_r : wp_r;
    rp_nxt  = do_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) buf_r[wp_r] <= wdata;
  end

endmodule

>>> sv/lpht_back.sv
// Back end: clears the used flags after reset, then walks the probe chain
// in the slot memory and issues one result beat per item. Uses lpht_pkg.
module lpht_back import lpht_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int IW = $clog2(TABLE_DEPTH),
  localparam int SW = IW + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [SW-1:0] eff_size,
  input  logic          q_empty,
  input  lpht_in_t      q_item,
  input  logic [IW-1:0] q_home,
  output logic          q_pop,
  output logic          clearing,
  output logic          out_valid,
  output lpht_out_t     out_item
);

  lpht_bk_state_t state_r, state_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic [SW-1:0]  cnt_r, cnt_nxt;
  logic [IW-1:0]  clr_r, clr_nxt;
  lpht_in_t       item_r, item_nxt;
  logic           ov_r, ov_nxt;
  lpht_out_t      oi_r, oi_nxt;

  lpht_entry_t    mem [TABLE_DEPTH];
  lpht_entry_t    rd_q;
  lpht_entry_t    wd;
  logic [IW-1:0]  wa;
  logic           we;

  logic [SW-1:0]  idx_inc;
  logic           last, hit, probe_done, clr_last;
  logic [SLOT_W-1:0] slot_cur;

  assign idx_inc    = {1'b0, idx_r} + 1'b1;
  assign last       = (cnt_r + 1'b1) == eff_size;
  assign hit        = (item_r.mode == MODE_SEARCH) && (rd_q.key == item_r.key);
  assign probe_done = !rd_q.used || hit || last;
  assign clr_last   = (clr_r == IW'(TABLE_DEPTH - 1));
  assign slot_cur   = SLOT_W'((IW + SLOT_W)'(idx_r));
  assign clearing   = (state_r == BK_CLEAR);
  assign out_valid  = ov_r;
  assign out_item   = oi_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_CLEAR: if (clr_last) state_nxt = BK_IDLE;
      BK_IDLE:  if (!q_empty) state_nxt = BK_READ;
      BK_READ:  state_nxt = BK_CHECK;
      BK_CHECK: state_nxt = probe_done ? BK_IDLE : BK_READ;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    clr_nxt  = clr_r;
    item_nxt = item_r;
    ov_nxt   = 1'b0;
    oi_nxt   = oi_r;
    q_pop    = 1'b0;
    we       = 1'b0;
    wa       = idx_r;
    wd       = '0;
    case (state_r)
      BK_CLEAR: begin
        we      = 1'b1;
        wa      = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          idx_nxt  = q_home;
          cnt_nxt  = '0;
        end
      end
      BK_CHECK: begin
        if (probe_done) begin
          ov_nxt = 1'b1;
          oi_nxt = '{slot: '0, status: ST_NOT_FOUND, found_payload: '0};
          if (item_r.mode == MODE_INSERT) begin
            if (!rd_q.used) begin
              we             = 1'b1;
              wd             = '{used: 1'b1, key: item_r.key, payload: item_r.payload};
              oi_nxt.slot    = slot_cur;
              oi_nxt.status  = ST_STORED;
            end else begin
              oi_nxt.status  = ST_FULL;
            end
          end else if (rd_q.used && hit) begin
            oi_nxt.slot          = slot_cur;
            oi_nxt.status        = ST_FOUND;
            oi_nxt.found_payload = rd_q.payload;
          end
        end else begin
          idx_nxt = (idx_inc == eff_size) ? '0 : idx_inc[IW-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    item_r <= item_nxt;
    oi_r   <= oi_nxt;
  end

endmodule

>>> sv/linear_probe_hash_table_core.sv
// Linear-probe hash table core: top level, size register and glue.
// Depends on lpht_pkg, lpht_front, lpht_queue and lpht_back.
//
// Use: present a command on in_item and raise start; it is taken at a clock
// edge where start is high and busy is low. mode 0 inserts key and payload,
// mode 1 searches for key. Each command gives one result beat: out_valid is
// high for exactly one cycle with out_item (slot, status, found_payload).
// The receiver cannot stall; every beat must be captured when it appears.
// Flow: the front end reduces the key modulo the table size (one quotient
// bit per cycle), pushes the item into the queue and the back end pops it;
// each probe in the back end is a registered slot memory read, then a
// compare, and the result passes through one output register; probes run
// from 1 to the table size. The front end can take a new command while the
// back end probes, but waits in its push state while the queue is full;
// sustained rate is set by the slower of the two.
// cfg_data sets table_size (clamped to 1..TABLE_DEPTH); cfg_ready is always
// high; write it only while the core is idle.
// Reset: synchronous active low; table_size returns to 128 and a clearing
// pass over all TABLE_DEPTH entries empties the table, with busy held high.
module linear_probe_hash_table_core import lpht_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lpht_in_t          in_item,
  output logic              out_valid,
  output lpht_out_t         out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int SW = IW + 1;
  localparam int CW = (SW > SIZE_W) ? SW : SIZE_W;
  localparam int QW = $bits(lpht_in_t) + IW;

  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [CW-1:0]     size_ext;
  logic [SW-1:0]     eff_size;

  logic          clearing;
  logic          q_push, q_full, q_pop, q_empty;
  lpht_in_t      fr_item, bk_item;
  logic [IW-1:0] fr_home, bk_home;
  logic [QW-1:0] q_rdata;

  assign cfg_ready = 1'b1;
  assign size_nxt  = (cfg_valid && cfg_ready) ? cfg_data : size_r;
  assign size_ext  = CW'(size_r);

  always_comb begin
    if (size_ext == '0) begin
      eff_size = SW'(1);
    end else if (size_ext > CW'(TABLE_DEPTH)) begin
      eff_size = SW'(TABLE_DEPTH);
    end else begin
      eff_size = size_ext[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else begin
      size_r <= size_nxt;
    end
  end

  lpht_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .eff_size (eff_size),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (fr_item),
    .q_home   (fr_home)
  );

  lpht_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({fr_item, fr_home}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign bk_item = q_rdata[QW-1:IW];
  assign bk_home = q_rdata[IW-1:0];

  lpht_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_size  (eff_size),
    .q_empty   (q_empty),
    .q_item    (bk_item),
    .q_home    (bk_home),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> test/testbench.sv
// Self-checking testbench for linear_probe_hash_table_core: directed and random
// insert/search beats checked against an in-bench shadow of the slot store.
// Depends on lpht_pkg and the core RTL only.
module testbench;
  import lpht_pkg::*;

  localparam int DEPTH        = TABLE_DEPTH_DEF;
  localparam int DRAIN_CYCLES = 34 + 2 * DEPTH + 10;
  localparam int STALL_LIMIT  = 4000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  logic              busy;
  lpht_in_t          in_item   = '0;
  logic              out_valid;
  lpht_out_t         out_item;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] cfg_data  = '0;

  // shadow of the slot store and the size register
  logic              shadow_used [DEPTH];
  logic [KEY_W-1:0]  shadow_key  [DEPTH];
  logic [PAY_W-1:0]  shadow_pay  [DEPTH];
  logic [SIZE_W-1:0] size_reg = SIZE_RESET;

  lpht_out_t         probe_outcomes[$];
  lpht_out_t         want;
  logic [KEY_W-1:0]  known_keys[$];
  int unsigned       gap_max = 10;
  int                error_count = 0;
  int                stall_cycles = 0;

  linear_probe_hash_table_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      shadow_used[i] = 1'b0;
      shadow_key[i]  = '0;
      shadow_pay[i]  = '0;
    end
  end

  function automatic lpht_out_t probe_table(input lpht_in_t cmd);
    int unsigned span;
    int unsigned idx;
    logic        done;
    lpht_out_t   res;
    span = (size_reg == 0) ? 1 : ((size_reg > DEPTH) ? DEPTH : size_reg);
    idx  = cmd.key % span;
    done = 1'b0;
    res.slot          = '0;
    res.status        = (cmd.mode == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
    res.found_payload = '0;
    for (int n = 0; n < span && !done; n++) begin
      if (cmd.mode == MODE_INSERT) begin
        if (!shadow_used[idx]) begin
          shadow_used[idx] = 1'b1;
          shadow_key[idx]  = cmd.key;
          shadow_pay[idx]  = cmd.payload;
          res.slot         = SLOT_W'(idx);
          res.status       = ST_STORED;
          done             = 1'b1;
        end
      end else begin
        if (!shadow_used[idx]) begin
          done = 1'b1;
        end else if (shadow_key[idx] == cmd.key) begin
          res.slot          = SLOT_W'(idx);
          res.status        = ST_FOUND;
          res.found_payload = shadow_pay[idx];
          done              = 1'b1;
        end
      end
      idx = (idx + 1 == span) ? 0 : idx + 1;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, exp_val);
    error_count++;
  endtask

  // result checking, prediction on each accepted beat, size register tracking
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (probe_outcomes.size() == 0) begin
          report_mismatch("result with none pending, slot", 32'(out_item.slot), 0);
        end else begin
          want = probe_outcomes.pop_front();
          if (out_item.slot !== want.slot)
            report_mismatch("slot", 32'(out_item.slot), 32'(want.slot));
          if (out_item.status !== want.status)
            report_mismatch("status", 32'(out_item.status), 32'(want.status));
          if (out_item.found_payload !== want.found_payload)
            report_mismatch("found_payload", out_item.found_payload, want.found_payload);
        end
      end
      if (cfg_valid && cfg_ready) size_reg = cfg_data;
      if (start && !busy) probe_outcomes.push_back(probe_table(in_item));
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("FAIL linear_probe_hash_table_core");
        $finish;
      end
    end
  end

  task automatic send_command(input logic mode, input logic [KEY_W-1:0] key,
                              input logic [PAY_W-1:0] payload);
    int unsigned gap;
    lpht_in_t    cmd;
    gap         = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    cmd.mode    = mode;
    cmd.key     = key;
    cmd.payload = payload;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= cmd;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (probe_outcomes.size() != 0);
    while (busy) @(posedge clk);
  endtask

  task automatic write_table_size(input logic [SIZE_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_empty_search();
    send_command(MODE_SEARCH, '0, 32'h1234_5678);
    send_command(MODE_SEARCH, {KEY_W{1'b1}}, '0);
  endtask

  task automatic test_insert_wrap();
    send_command(MODE_INSERT, '0, '0);
    send_command(MODE_INSERT, {KEY_W{1'b1}}, {PAY_W{1'b1}});
    send_command(MODE_INSERT, KEY_W'(127), 32'hA5A5_A5A5);
    send_command(MODE_SEARCH, {KEY_W{1'b1}}, '0);
    send_command(MODE_SEARCH, KEY_W'(127), {PAY_W{1'b1}});
    send_command(MODE_SEARCH, KEY_W'(255), '0);
    send_command(MODE_SEARCH, '0, '0);
  endtask

  task automatic test_duplicate_keys();
    send_command(MODE_INSERT, KEY_W'(2), 32'h0000_1111);
    send_command(MODE_INSERT, KEY_W'(2), 32'h0000_2222);
    send_command(MODE_SEARCH, KEY_W'(2), '0);
  endtask

  // size 0 acts as one slot; size 2 is already full
  task automatic test_size_clamp();
    write_table_size('0);
    send_command(MODE_INSERT, KEY_W'(5), 32'h5A5A_5A5A);
    send_command(MODE_SEARCH, KEY_W'(5), '0);
    send_command(MODE_SEARCH, KEY_W'(32'h4000_0000), '0);
    send_command(MODE_SEARCH, '0, '0);
    write_table_size(SIZE_W'(2));
    send_command(MODE_INSERT, KEY_W'(9), 32'hDEAD_BEEF);
    send_command(MODE_SEARCH, KEY_W'(127), '0);
  endtask

  // oversize clamps to full depth; records above the small size are still there
  task automatic test_size_restore();
    write_table_size({SIZE_W{1'b1}});
    send_command(MODE_SEARCH, {KEY_W{1'b1}}, '0);
    send_command(MODE_INSERT, KEY_W'(131), 32'hC0DE_0131);
    send_command(MODE_SEARCH, KEY_W'(131), '0);
  endtask

  task automatic test_random_phase(input logic [SIZE_W-1:0] size_value, input int items,
                                   input int unsigned idle_max);
    logic             mode;
    logic [KEY_W-1:0] key;
    int unsigned      pick;
    write_table_size(size_value);
    gap_max = idle_max;
    repeat (items) begin
      mode = ($urandom_range(0, 99) < 45) ? MODE_INSERT : MODE_SEARCH;
      pick = $urandom_range(0, 9);
      if (known_keys.size() != 0 && pick < ((mode == MODE_SEARCH) ? 6 : 2)) begin
        key = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else begin
        case (pick % 3)
          0: begin
            key = KEY_W'($urandom_range(0, 511));
          end
          1: begin
            key = KEY_W'($urandom);
          end
          default: begin
            key = {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 255));
          end
        endcase
      end
      if (mode == MODE_INSERT) known_keys.push_back(key);
      send_command(mode, key, $urandom);
      if ($urandom_range(0, 59) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_search();
    test_insert_wrap();
    test_duplicate_keys();
    test_size_clamp();
    test_size_restore();
    test_random_phase(SIZE_W'(3),   100, 10);
    test_random_phase(SIZE_W'(0),   100, 0);
    test_random_phase(SIZE_W'(10),  100, 10);
    test_random_phase(SIZE_W'(1),   100, 3);
    test_random_phase(SIZE_W'(24),  100, 0);
    test_random_phase(SIZE_W'(2),   100, 10);
    test_random_phase(SIZE_W'(48),  100, 10);
    test_random_phase(SIZE_W'(255), 100, 0);
    test_random_phase(SIZE_W'(80),  100, 10);
    test_random_phase(SIZE_W'(128), 100, 5);
    test_random_phase(SIZE_W'(200), 100, 0);
    test_random_phase(SIZE_W'(128), 100, 10);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS linear_probe_hash_table_core");
    end else begin
      $display("FAIL linear_probe_hash_table_core");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lpht_pkg.sv
sv/lpht_front.sv
sv/lpht_queue.sv
sv/lpht_back.sv
sv/linear_probe_hash_table_core.sv
test/testbench.sv
